FILE: hdl/blg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level gauge package
// Shared types, constants and register codes for the battery level gauge.
// ----------------------------------------------------------------------------
package blg_pkg;

  localparam int WINDOW      = 8;
  localparam int WIN_AW      = $clog2(WINDOW);
  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = SAMPLE_W + WIN_AW;
  localparam int RAW_W       = 10;
  localparam int OFS_W       = 8;
  localparam int CALC_W      = SAMPLE_W + 1;
  localparam int LEVEL_W     = 3;
  localparam int EMPTY_CALLS = 4;
  localparam int EC_W        = $clog2(EMPTY_CALLS + 2);
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 12;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_W-1:0] TH1_RST    = 12'h00D;
  localparam logic [SAMPLE_W-1:0] TH2_RST    = 12'h01A;
  localparam logic [SAMPLE_W-1:0] TH3_RST    = 12'h035;
  localparam logic [SAMPLE_W-1:0] TH4_RST    = 12'h05C;
  localparam logic [SAMPLE_W-1:0] CAL_RST    = 12'h000;
  localparam logic [OFS_W-1:0]    CHARGE_RST = 8'd15;
  localparam logic [OFS_W-1:0]    LENS_RST   = 8'd23;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_TH1    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TH2    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_TH3    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_TH4    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CAL    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CHARGE = 3'd5;
  localparam logic [CFG_AW-1:0] REG_LENS   = 3'd6;

  // Level codes.
  localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

  typedef struct packed {
    logic [RAW_W-1:0] adc_raw;
    logic             charging;
    logic             lens_moving;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic                empty_res;
    logic [SAMPLE_W-1:0] average;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic accum;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_entry;
  } status_t;

endpackage

FILE: hdl/battery_level_gauge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level gauge
// Windowed battery level detector with debounce and empty detection.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries one raw converter sample and the charging and
// lens-moving flags. Each input beat produces exactly one output beat with
// the debounced level, the empty flag and the window mean.
// One sample is in progress at a time; the window sum is built one entry
// per cycle from the eight window registers through a single adder.
// A new sample is taken while the previous result still waits in the output
// register; if the receiver stalls, the block finishes the next sample and
// then holds it until the output register is drained.
// Reset (synchronous, active high) restores the configuration defaults, empties
// the output and restarts the window, which the next sample fills entirely.
// Configuration writes act at once; the user must make them while idle (unchecked).
// ----------------------------------------------------------------------------
module battery_level_gauge_unit
  import blg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  cmd_t    cmd;
  status_t sts;

  blg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  blg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/blg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level gauge controller
// Sequences capture, window update, summation and result commit.
// ----------------------------------------------------------------------------
module blg_ctrl
  import blg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output register can take a new result if it is empty or being drained.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sts.last_entry) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_SUM: begin
        cmd.accum = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/blg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level gauge datapath
// Configuration registers, sample compensation, window, running sum,
// level classification, debounce and empty detection.
// ----------------------------------------------------------------------------
module blg_dp
  import blg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  in_item_t          in_data,
  input  cmd_t              cmd,
  output status_t           sts,
  output out_item_t         out_data
);

  logic [SAMPLE_W-1:0] th1;
  logic [SAMPLE_W-1:0] th2;
  logic [SAMPLE_W-1:0] th3;
  logic [SAMPLE_W-1:0] th4;
  logic [SAMPLE_W-1:0] cal_offset;
  logic [OFS_W-1:0]    charge_offset;
  logic [OFS_W-1:0]    lens_offset;

  in_item_t            item;
  logic [SAMPLE_W-1:0] sample_window [WINDOW];
  logic [WIN_AW-1:0]   write_index;
  logic [WIN_AW-1:0]   rd_index;
  logic [SUM_W-1:0]    sum;
  logic                started;
  logic [LEVEL_W-1:0]  previous_level;
  logic [LEVEL_W-1:0]  held_level;
  logic                call_parity;
  logic [EC_W-1:0]     empty_count;

  logic signed [CALC_W-1:0] cal_ext;
  logic signed [CALC_W-1:0] cal_half;
  logic signed [CALC_W-1:0] comp_sum;
  logic [OFS_W-1:0]         add_ofs;
  logic [SAMPLE_W-1:0]      comp;
  logic [SAMPLE_W-1:0]      avg;
  logic [LEVEL_W-1:0]       cur_level;
  logic [LEVEL_W-1:0]       held_next;
  logic [EC_W-1:0]          empty_count_next;
  logic                     empty_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      th1           <= TH1_RST;
      th2           <= TH2_RST;
      th3           <= TH3_RST;
      th4           <= TH4_RST;
      cal_offset    <= CAL_RST;
      charge_offset <= CHARGE_RST;
      lens_offset   <= LENS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TH1:    th1           <= cfg_data[SAMPLE_W-1:0];
        REG_TH2:    th2           <= cfg_data[SAMPLE_W-1:0];
        REG_TH3:    th3           <= cfg_data[SAMPLE_W-1:0];
        REG_TH4:    th4           <= cfg_data[SAMPLE_W-1:0];
        REG_CAL:    cal_offset    <= cfg_data[SAMPLE_W-1:0];
        REG_CHARGE: charge_offset <= cfg_data[OFS_W-1:0];
        REG_LENS:   lens_offset   <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // Half of the calibration offset, rounded toward zero: bias negative
  // values by one before the arithmetic shift.
  assign cal_ext  = signed'({cal_offset[SAMPLE_W-1], cal_offset});
  assign cal_half = (cal_ext + signed'(CALC_W'(cal_offset[SAMPLE_W-1]))) >>> 1;

  always_comb begin
    if (item.charging) begin
      add_ofs = charge_offset;
    end else if (item.lens_moving) begin
      add_ofs = lens_offset;
    end else begin
      add_ofs = '0;
    end
  end

  assign comp_sum = signed'(CALC_W'(item.adc_raw)) + signed'(CALC_W'(add_ofs)) + cal_half;

  // The sum never exceeds the upper bound, so only negatives need clamping.
  assign comp = comp_sum[CALC_W-1] ? '0 : comp_sum[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (!started) begin
        for (int i = 0; i < WINDOW; i++) begin
          sample_window[i] <= comp;
        end
      end else begin
        sample_window[write_index] <= comp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else if (cmd.load && started) begin
      write_index <= write_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum      <= '0;
      rd_index <= '0;
    end else if (cmd.accum) begin
      sum      <= sum + SUM_W'(sample_window[rd_index]);
      rd_index <= rd_index + 1'b1;
    end
  end

  assign sts.last_entry = (rd_index == WIN_AW'(WINDOW - 1));

  assign avg = sum[SUM_W-1:WIN_AW];

  always_comb begin
    priority if (avg > th4) cur_level = LEVEL_4;
    else if (avg > th3)     cur_level = LEVEL_3;
    else if (avg > th2)     cur_level = LEVEL_2;
    else if (avg > th1)     cur_level = LEVEL_1;
    else                    cur_level = LEVEL_0;
  end

  // Every second call after reset keeps the held level unless the new level repeats the last one.
  always_comb begin
    if (!started || cur_level == previous_level || !call_parity) begin
      held_next = cur_level;
    end else begin
      held_next = held_level;
    end
  end

  always_comb begin
    empty_count_next = empty_count;
    empty_flag       = 1'b0;
    if (empty_count != '0 || held_next == LEVEL_0) begin
      if (empty_count <= EC_W'(EMPTY_CALLS)) begin
        empty_count_next = empty_count + 1'b1;
      end
      empty_flag = (empty_count_next == EC_W'(EMPTY_CALLS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      previous_level <= LEVEL_0;
      held_level     <= LEVEL_0;
      call_parity    <= 1'b0;
      empty_count    <= '0;
    end else if (cmd.commit) begin
      started        <= 1'b1;
      previous_level <= cur_level;
      held_level     <= held_next;
      call_parity    <= !call_parity;
      empty_count    <= empty_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.level     <= held_next;
      out_data.empty_res <= empty_flag;
      out_data.average   <= avg;
    end
  end

endmodule

FILE: hdl/blg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level gauge checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module blg_checker
  import blg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // The block works on one sample at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  // No result can appear right after a sample is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared in the cycle after an input beat");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.level <= LEVEL_4)
    else $error("level out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind battery_level_gauge_unit blg_checker u_blg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
